// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

   localparam int DATA_W = 64;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPONENT = 1'b1;

   localparam logic [DATA_W-1:0] MODULUS_RESET = 64'd3;
   localparam logic [DATA_W-1:0] EXPONENT_RESET = 64'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_COMMIT,
      ST_HOLD
   } mexp_state_type;

   typedef struct packed {
      logic load;
      logic red_step;
      logic mul_start;
      logic mul_step;
      logic commit;
      logic out_load;
   } mexp_cmd_type;

   typedef struct packed {
      logic n_small;
      logic e_done;
   } mexp_status_type;

endpackage

// ===== rtl/mexp_dp.sv =====
module mexp_dp #(
   parameter int WIDTH = 64
) (
   input  logic                         clock,
   input  mexp_pkg::mexp_cmd_type       cmd,
   output mexp_pkg::mexp_status_type    status,
   input  logic [mexp_pkg::DATA_W-1:0]  base,
   input  logic [mexp_pkg::DATA_W-1:0]  modulus,
   input  logic [mexp_pkg::DATA_W-1:0]  exponent,
   output logic [mexp_pkg::DATA_W-1:0]  result
);

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] pa_ff, pa_in;
   logic [WIDTH-1:0] ps_ff, ps_in;
   logic [mexp_pkg::DATA_W-1:0] res_ff, res_in;

   logic [WIDTH:0]   red_t;
   logic [WIDTH+1:0] red_d;
   logic [WIDTH-1:0] red_next;

   // (2p + (take ? x : 0)) mod m, with p < m and x < m
   function automatic logic [WIDTH-1:0] dbl_add_mod(
      input logic [WIDTH-1:0] p,
      input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] m,
      input logic             take
   );
      logic [WIDTH+1:0] t;
      logic [WIDTH+1:0] d1;
      logic [WIDTH+1:0] d2;
      t  = {1'b0, p, 1'b0} + (take ? {2'b00, x} : '0);
      d1 = t - {2'b00, m};
      d2 = t - {1'b0, m, 1'b0};
      if (!d2[WIDTH+1]) begin
         return d2[WIDTH-1:0];
      end else if (!d1[WIDTH+1]) begin
         return d1[WIDTH-1:0];
      end
      return t[WIDTH-1:0];
   endfunction

   // one restoring step of base mod n, base bits enter from the top
   always_comb begin
      red_t = {sq_ff, shift_ff[WIDTH-1]};
      red_d = {1'b0, red_t} - {2'b00, n_ff};
      red_next = red_d[WIDTH+1] ? red_t[WIDTH-1:0] : red_d[WIDTH-1:0];
   end

   always_comb begin
      n_in = n_ff;
      e_in = e_ff;
      shift_in = shift_ff;
      sq_in = sq_ff;
      acc_in = acc_ff;
      pa_in = pa_ff;
      ps_in = ps_ff;
      res_in = res_ff;
      if (cmd.load) begin
         n_in = modulus[WIDTH-1:0];
         e_in = exponent[WIDTH-1:0];
         shift_in = base[WIDTH-1:0];
         sq_in = '0;
         acc_in = WIDTH'(1);
      end
      if (cmd.red_step) begin
         sq_in = red_next;
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
      end
      if (cmd.mul_start) begin
         shift_in = sq_ff;
         pa_in = '0;
         ps_in = '0;
      end
      if (cmd.mul_step) begin
         // both products scan the bits of the current square
         pa_in = dbl_add_mod(pa_ff, acc_ff, n_ff, shift_ff[WIDTH-1]);
         ps_in = dbl_add_mod(ps_ff, sq_ff, n_ff, shift_ff[WIDTH-1]);
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
      end
      if (cmd.commit) begin
         if (e_ff[0]) begin
            acc_in = pa_ff;
         end
         sq_in = ps_ff;
         e_in = e_ff >> 1;
      end
      if (cmd.out_load) begin
         res_in = status.n_small ? '0 : mexp_pkg::DATA_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      e_ff <= e_in;
      shift_ff <= shift_in;
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      pa_ff <= pa_in;
      ps_ff <= ps_in;
      res_ff <= res_in;
   end

   assign status.n_small = (n_ff >> 1) == '0;
   assign status.e_done = e_ff == '0;
   assign result = res_ff;

endmodule

// ===== rtl/mexp_ctrl.sv =====
module mexp_ctrl #(
   parameter int WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output mexp_pkg::mexp_cmd_type     cmd,
   input  mexp_pkg::mexp_status_type  status
);

   localparam int CNT_W = $clog2(WIDTH);

   mexp_pkg::mexp_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             cnt_last;
   logic             out_free;

   assign cnt_last = cnt_ff == CNT_W'(WIDTH - 1);
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = mexp_pkg::ST_REDUCE;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (cnt_last) begin
               state_in = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_CHECK: begin
            if (status.n_small || status.e_done) begin
               state_in = mexp_pkg::ST_HOLD;
            end else begin
               state_in = mexp_pkg::ST_MUL;
            end
         end
         mexp_pkg::ST_MUL: begin
            if (cnt_last) begin
               state_in = mexp_pkg::ST_COMMIT;
            end
         end
         mexp_pkg::ST_COMMIT: begin
            state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         mexp_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
         end
         mexp_pkg::ST_CHECK: begin
            cmd.mul_start = !(status.n_small || status.e_done);
         end
         mexp_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         mexp_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         mexp_pkg::ST_HOLD: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if ((state_ff == mexp_pkg::ST_REDUCE || state_ff == mexp_pkg::ST_MUL) && !cnt_last) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = '0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == mexp_pkg::ST_REDUCE && cnt_ff == '0))
      else $error("accepted request did not start reduction");

   a_mul_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> (state_ff == mexp_pkg::ST_MUL && cnt_ff == '0))
      else $error("multiply pass entered with a stale count");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.red_step, cmd.mul_start, cmd.mul_step, cmd.commit,
                cmd.out_load}))
      else $error("more than one datapath command");

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
// Computes base^exponent mod modulus on WIDTH-bit unsigned values (the low WIDTH bits of each
// 64-bit field are used), scanning the exponent from its lowest bit up. A request is held in the
// datapath for its whole run: base is first reduced mod modulus one bit per cycle, then for
// each exponent bit up to the highest set one a bit-serial pass forms the running product and
// the next square together, between a check state and a commit state. Each multiply lane has a
// single double-and-add-mod step. A new request is taken once the previous result sits in the
// output register, even if it has not been taken yet. Modulus below 2 gives 0, exponent zero
// gives 1. Registers: index 0 modulus (reset 3), index 1 exponent (reset 1); write them only
// while no request is in progress.
module modular_exponentiation_top #(
   parameter int WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mexp_pkg::DATA_W-1:0]         req_tdata,  // [63:0] base
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mexp_pkg::DATA_W-1:0]         rsp_tdata,  // [63:0] result
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mexp_pkg::DATA_W-1:0]         csr_data
);

   logic [mexp_pkg::DATA_W-1:0] modulus_ff, modulus_in;
   logic [mexp_pkg::DATA_W-1:0] exponent_ff, exponent_in;
   mexp_pkg::mexp_cmd_type      cmd;
   mexp_pkg::mexp_status_type   status;

   assign csr_ready = 1'b1;

   always_comb begin
      modulus_in = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_valid) begin
         case (csr_index)
            mexp_pkg::CSR_MODULUS: modulus_in = csr_data;
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_data;
            default: begin
               modulus_in = modulus_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::MODULUS_RESET;
         exponent_ff <= mexp_pkg::EXPONENT_RESET;
      end else begin
         modulus_ff <= modulus_in;
         exponent_ff <= exponent_in;
      end
   end

   mexp_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mexp_dp #(
      .WIDTH(WIDTH)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .status   (status),
      .base     (req_tdata),
      .modulus  (modulus_ff),
      .exponent (exponent_ff),
      .result   (rsp_tdata)
   );

endmodule
